// ===== src/sfs_pkg.sv =====
`default_nettype none
package sfs_pkg;

  // default sizes
  localparam int RING_DEPTH_DEF = 64;
  localparam int FRAME_MASK_DEF = 255;

  // timer reload constants
  localparam logic [7:0]  GAP_HI   = 8'hD1;
  localparam logic [7:0]  GAP_LO   = 8'h1F;
  localparam logic [7:0]  END_HI   = 8'hE9;
  localparam logic [7:0]  END_LO   = 8'h90;
  localparam logic [15:0] GAP_LOAD = {GAP_HI, GAP_LO};
  localparam logic [15:0] END_LOAD = {END_HI, END_LO};

  // action codes on the input channel
  localparam logic [2:0] ACT_TIMER  = 3'd0;
  localparam logic [2:0] ACT_RX     = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_PULSE  = 3'd3;
  localparam logic [2:0] ACT_FRAMES = 3'd4;

  // frame slots
  localparam logic [2:0] SLOT_PULSE   = 3'd0;
  localparam logic [2:0] SLOT_OPEN    = 3'd1;
  localparam logic [2:0] SLOT_GAP_BEG = 3'd2;
  localparam logic [2:0] SLOT_GAP_END = 3'd5;

  typedef enum logic [2:0] {
    OP_TIMER,
    OP_RX,
    OP_READ,
    OP_PULSE,
    OP_FRAMES,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  rx_data;
    logic [15:0] pulse_width;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/sfs_if.sv =====
`default_nettype none
// input item channel
interface sfs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  rx_data;
  logic [15:0] pulse_width;

  modport source (output valid, action, rx_data, pulse_width, input ready);
  modport sink   (input valid, action, rx_data, pulse_width, output ready);
endinterface

// result item channel
interface sfs_out_if;
  logic        valid;
  logic        ready;
  logic        servo_level;
  logic [15:0] timer_load;
  logic        receiver_on;
  logic [7:0]  read_data;
  logic [5:0]  fill_count;
  logic [7:0]  frames_elapsed;

  modport source (output valid, servo_level, timer_load, receiver_on, read_data,
                  fill_count, frames_elapsed, input ready);
  modport sink   (input valid, servo_level, timer_load, receiver_on, read_data,
                  fill_count, frames_elapsed, output ready);
endinterface
`default_nettype wire

// ===== src/sfs_ram.sv =====
`default_nettype none
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/sfs_front.sv =====
`default_nettype none
module sfs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sfs_in_if.sink             in_i,
  output logic               cmd_valid_o,
  output sfs_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_ready_i
);

  sfs_pkg::cmd_t entry_q [2];
  sfs_pkg::cmd_t cls;
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  // classify the incoming action
  always_comb begin
    cls.rx_data     = in_i.rx_data;
    cls.pulse_width = in_i.pulse_width;
    case (in_i.action)
      sfs_pkg::ACT_TIMER:  cls.op = sfs_pkg::OP_TIMER;
      sfs_pkg::ACT_RX:     cls.op = sfs_pkg::OP_RX;
      sfs_pkg::ACT_READ:   cls.op = sfs_pkg::OP_READ;
      sfs_pkg::ACT_PULSE:  cls.op = sfs_pkg::OP_PULSE;
      sfs_pkg::ACT_FRAMES: cls.op = sfs_pkg::OP_FRAMES;
      default:             cls.op = sfs_pkg::OP_NONE;
    endcase
  end

  // two-entry queue toward the back end
  assign in_i.ready  = (count_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== src/sfs_back.sv =====
`default_nettype none
module sfs_back #(
  parameter int RING_DEPTH = sfs_pkg::RING_DEPTH_DEF,
  parameter int FRAME_MASK = sfs_pkg::FRAME_MASK_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire logic          cmd_valid_i,
  input  wire sfs_pkg::cmd_t cmd_i,
  output logic               cmd_ready_o,
  sfs_out_if.source          out_o
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int FW = PW + 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F  = FW'(RING_DEPTH);
  localparam logic [9:0]    MOD_F    = 10'(FRAME_MASK + 1);
  localparam logic [7:0]    MASK_B   = 8'(FRAME_MASK);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic            state_q, state_d;
  logic [15:0]     offset_q;
  logic [2:0]      slot_q, slot_d;
  logic [15:0]     pulse_load_q, pulse_load_d;
  logic            rx_en_q, rx_en_d;
  logic [PW-1:0]   head_q, head_d;
  logic [PW-1:0]   tail_q, tail_d;
  logic [7:0]      fc_q, fc_d;
  logic [7:0]      last_q, last_d;
  logic [RING_DEPTH-1:0] valid_q;
  logic            rd_valid_q;

  logic            out_free, pop;
  logic            ram_we, ram_re;
  logic [7:0]      ram_rdata;
  logic [15:0]     load;
  logic [7:0]      frames;
  logic [9:0]      frames_sum;
  logic [FW-1:0]   fill_full;

  logic            ov_q;
  logic            servo_q;
  logic [15:0]     load_q;
  logic            rxon_q;
  logic [7:0]      rdata_q;
  logic [5:0]      fill_q;
  logic [7:0]      frames_q;

  assign out_free    = !ov_q || out_o.ready;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // ring pointer wrap helper
  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign frames_sum = {2'b00, fc_q} + MOD_F - {2'b00, last_q};

  // execute one command
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    pulse_load_d = pulse_load_q;
    rx_en_d      = rx_en_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fc_d         = fc_q;
    last_d       = last_q;
    load         = 16'h0000;
    frames       = 8'h00;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    if (state_q == ST_READ) begin
      state_d = ST_IDLE;
    end else if (pop) begin
      case (cmd_i.op)
        sfs_pkg::OP_TIMER: begin
          if (slot_q == sfs_pkg::SLOT_PULSE) begin
            rx_en_d = 1'b0;
            load    = pulse_load_q;
            slot_d  = sfs_pkg::SLOT_OPEN;
          end else if (slot_q == sfs_pkg::SLOT_OPEN) begin
            tail_d  = head_q;
            rx_en_d = 1'b1;
            load    = sfs_pkg::GAP_LOAD;
            slot_d  = sfs_pkg::SLOT_GAP_BEG;
          end else if (slot_q inside {[sfs_pkg::SLOT_GAP_BEG:sfs_pkg::SLOT_GAP_END]}) begin
            load   = sfs_pkg::GAP_LOAD;
            slot_d = slot_q + 3'd1;
          end else begin
            load   = sfs_pkg::END_LOAD;
            slot_d = sfs_pkg::SLOT_PULSE;
            fc_d   = (fc_q + 8'd1) & MASK_B;
          end
        end
        sfs_pkg::OP_RX: begin
          if (rx_en_q) begin
            ram_we = 1'b1;
            head_d = ring_next(head_q);
          end
        end
        sfs_pkg::OP_READ: begin
          ram_re  = 1'b1;
          state_d = ST_READ;
          if (head_q != tail_q) begin
            tail_d = ring_next(tail_q);
          end
        end
        sfs_pkg::OP_PULSE: begin
          pulse_load_d = offset_q - cmd_i.pulse_width;
        end
        sfs_pkg::OP_FRAMES: begin
          frames = frames_sum[7:0] & MASK_B;
          last_d = fc_q;
        end
        default: begin
        end
      endcase
    end
  end

  // fill count after the command
  assign fill_full = {1'b0, head_d} + ((tail_d > head_d) ? DEPTH_F : '0) - {1'b0, tail_d};

  // control and ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      offset_q     <= 16'h0000;
      slot_q       <= sfs_pkg::SLOT_PULSE;
      pulse_load_q <= 16'h0000;
      rx_en_q      <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      fc_q         <= 8'h00;
      last_q       <= 8'h00;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      slot_q       <= slot_d;
      pulse_load_q <= pulse_load_d;
      rx_en_q      <= rx_en_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      fc_q         <= fc_d;
      last_q       <= last_d;
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        valid_q[head_q] <= 1'b1;
      end
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_valid_q <= valid_q[tail_q];
    end
  end

  sfs_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (cmd_i.rx_data),
    .re_i    (ram_re),
    .raddr_i (tail_q),
    .rdata_o (ram_rdata)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if ((state_q == ST_READ) || (pop && (cmd_i.op != sfs_pkg::OP_READ))) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_READ) || (pop && (cmd_i.op != sfs_pkg::OP_READ))) begin
      servo_q  <= (slot_d == sfs_pkg::SLOT_OPEN);
      load_q   <= load;
      rxon_q   <= rx_en_d;
      rdata_q  <= ((state_q == ST_READ) && rd_valid_q) ? ram_rdata : 8'h00;
      fill_q   <= 6'(fill_full);
      frames_q <= frames;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.servo_level    = servo_q;
  assign out_o.timer_load     = load_q;
  assign out_o.receiver_on    = rxon_q;
  assign out_o.read_data      = rdata_q;
  assign out_o.fill_count     = fill_q;
  assign out_o.frames_elapsed = frames_q;

`ifndef ASSERT_OFF
  a_read_wait_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !ov_q)
    else $error("read wait entered with a result still pending");

  a_read_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (cmd_i.op == sfs_pkg::OP_READ)) |=> (state_q == ST_READ))
    else $error("read command did not enter the wait state");

  a_write_needs_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (rx_en_q && pop))
    else $error("ring written while receiver disabled");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_full < DEPTH_F)
    else $error("fill count out of range");
`endif

endmodule
`default_nettype wire

// ===== src/servo_frame_sequencer_rx_ring.sv =====
// Servo frame sequencer with receive ring.
// Channels: in_i carries action, rx_data and pulse_width; out_o returns one
// result per item (servo level, timer load, receiver state, read byte, fill
// count, frames elapsed). Both use valid/ready; a transfer happens on a
// rising edge with valid and ready high. cfg_we_i/cfg_wdata_i write the pulse
// offset; the user must keep to writing it only while the block is idle, as the block has no check for it.
// A result passes the queue and the output register; a read also passes the
// registered ring memory read. Throughput: one item per cycle while out_o is
// ready, except a read, which holds the executing stage in its read wait
// state before the next item. A two-entry queue sits between the classifying
// front and the executing back, and an output register holds the result.
// Reset (async, active low): slot 0, receiver off, ring empty, counters and
// the pulse load cleared; ring entries read as zero until written, tracked by
// one valid flop per entry, so there is no clearing pass.
// When out_o stalls, the output register holds its result, the back end stops
// and the queue fills; in_i.ready drops once both queue entries are taken.
`default_nettype none
module servo_frame_sequencer_rx_ring #(
  parameter int RING_DEPTH = sfs_pkg::RING_DEPTH_DEF,
  parameter int FRAME_MASK = sfs_pkg::FRAME_MASK_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  sfs_in_if.sink           in_i,
  sfs_out_if.source        out_o
);

  logic          cmd_valid;
  logic          cmd_ready;
  sfs_pkg::cmd_t cmd;

  // accept and classify
  sfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // execute and report
  sfs_back #(
    .RING_DEPTH (RING_DEPTH),
    .FRAME_MASK (FRAME_MASK)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // spare action codes, no effect on state
  localparam logic [2:0] ACT_SPARE_A = 3'd5;
  localparam logic [2:0] ACT_SPARE_B = 3'd6;
  localparam logic [2:0] ACT_SPARE_C = 3'd7;

  localparam int RING_N      = sfs_pkg::RING_DEPTH_DEF;
  localparam int RING_W      = $clog2(RING_N);
  localparam int FRAME_M     = sfs_pkg::FRAME_MASK_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic        servo_level;
    logic [15:0] timer_load;
    logic        receiver_on;
    logic [7:0]  read_data;
    logic [5:0]  fill_count;
    logic [7:0]  frames_elapsed;
  } servo_result_t;

  typedef struct packed {
    logic [2:0]    act;
    logic [7:0]    rx;
    logic [15:0]   pw;
    logic          typed;
    servo_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  sfs_in_if  in_ch ();
  sfs_out_if out_ch ();

  servo_frame_sequencer_rx_ring u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow state of the sequencer
  logic [15:0]   offset_reg;
  logic [2:0]    cur_slot;
  logic [15:0]   pulse_load;
  logic          rx_on;
  logic [7:0]    ring_mem [RING_N];
  int            ring_head;
  int            ring_tail;
  logic [7:0]    frame_cnt;
  logic [7:0]    last_seen;

  servo_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int            err_cnt = 0;
  int            cycle_cnt = 0;
  bit            idle_en = 1'b1;

  // next result of the sequencer for one item, updates shadow state
  function automatic servo_result_t compute_servo_result(logic [2:0] act, logic [7:0] rx,
                                                          logic [15:0] pw);
    servo_result_t r;
    r = '0;
    case (act)
      sfs_pkg::ACT_TIMER: begin
        if (cur_slot == sfs_pkg::SLOT_PULSE) begin
          rx_on        = 1'b0;
          r.timer_load = pulse_load;
          cur_slot     = sfs_pkg::SLOT_OPEN;
        end else if (cur_slot == sfs_pkg::SLOT_OPEN) begin
          ring_tail    = ring_head;
          rx_on        = 1'b1;
          r.timer_load = sfs_pkg::GAP_LOAD;
          cur_slot     = sfs_pkg::SLOT_GAP_BEG;
        end else if (cur_slot <= sfs_pkg::SLOT_GAP_END) begin
          r.timer_load = sfs_pkg::GAP_LOAD;
          cur_slot     = cur_slot + 3'd1;
        end else begin
          // end slot, and the unreachable slot seven too
          r.timer_load = sfs_pkg::END_LOAD;
          cur_slot     = sfs_pkg::SLOT_PULSE;
          frame_cnt    = 8'((int'(frame_cnt) + 1) & FRAME_M);
        end
      end
      sfs_pkg::ACT_RX: begin
        if (rx_on) begin
          ring_mem[RING_W'(ring_head)] = rx;
          ring_head = (ring_head + 1) % RING_N;
        end
      end
      sfs_pkg::ACT_READ: begin
        r.read_data = ring_mem[RING_W'(ring_tail)];
        if (ring_head != ring_tail) ring_tail = (ring_tail + 1) % RING_N;
      end
      sfs_pkg::ACT_PULSE: begin
        pulse_load = offset_reg - pw;
      end
      sfs_pkg::ACT_FRAMES: begin
        r.frames_elapsed = 8'((int'(frame_cnt) + FRAME_M + 1 - int'(last_seen)) & FRAME_M);
        last_seen = frame_cnt;
      end
      default: begin
      end
    endcase
    r.servo_level = (cur_slot == sfs_pkg::SLOT_OPEN);
    r.receiver_on = rx_on;
    r.fill_count  = 6'((ring_head + RING_N - ring_tail) % RING_N);
    return r;
  endfunction

  function automatic servo_result_t mk_result(logic level, logic [15:0] load, logic rxon,
                                              logic [7:0] rd, logic [5:0] fill,
                                              logic [7:0] frames);
    servo_result_t r;
    r.servo_level    = level;
    r.timer_load     = load;
    r.receiver_on    = rxon;
    r.read_data      = rd;
    r.fill_count     = fill;
    r.frames_elapsed = frames;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] act, input logic [7:0] rx, input logic [15:0] pw,
                         input logic typed, input servo_result_t want);
    stim_row_t row;
    row.act   = act;
    row.rx    = rx;
    row.pw    = pw;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // one input transfer, called and returning at a falling edge
  task automatic send_item(input logic [2:0] act, input logic [7:0] rx, input logic [15:0] pw,
                           input logic typed, input servo_result_t want);
    servo_result_t pred;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.rx_data     <= rx;
    in_ch.pulse_width <= pw;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pred = compute_servo_result(act, rx, pw);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic send_random(input logic [2:0] act);
    send_item(act, 8'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  // drain all results, then let the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_offset(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    offset_reg = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result sink with random stall bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    servo_result_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual load %h fill %h", $time,
                 out_ch.timer_load, out_ch.fill_count);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("servo_level", 16'(want.servo_level), 16'(out_ch.servo_level));
        check_field("timer_load", want.timer_load, out_ch.timer_load);
        check_field("receiver_on", 16'(want.receiver_on), 16'(out_ch.receiver_on));
        check_field("read_data", 16'(want.read_data), 16'(out_ch.read_data));
        check_field("fill_count", 16'(want.fill_count), 16'(out_ch.fill_count));
        check_field("frames_elapsed", 16'(want.frames_elapsed), 16'(out_ch.frames_elapsed));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("servo_frame_sequencer_rx_ring test failed");
      $finish;
    end
  end

  initial begin
    int          i;
    int          n;
    int          pick;
    int          burst;
    logic [15:0] phase_offset;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = sfs_pkg::ACT_TIMER;
    in_ch.rx_data     = '0;
    in_ch.pulse_width = '0;

    offset_reg = '0;
    cur_slot   = sfs_pkg::SLOT_PULSE;
    pulse_load = '0;
    rx_on      = 1'b0;
    ring_head  = 0;
    ring_tail  = 0;
    frame_cnt  = '0;
    last_seen  = '0;
    for (i = 0; i < RING_N; i++) ring_mem[RING_W'(i)] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, offset at its top value
    write_offset(16'hFFFF);
    add_row(sfs_pkg::ACT_FRAMES, 8'h00, 16'h0000, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b0, 8'h00, 6'd0, 8'h00));
    add_row(sfs_pkg::ACT_READ, 8'h00, 16'h0000, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b0, 8'h00, 6'd0, 8'h00));
    // byte while the receiver is off is dropped
    add_row(sfs_pkg::ACT_RX, 8'hFF, 16'hFFFF, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b0, 8'h00, 6'd0, 8'h00));
    add_row(ACT_SPARE_C, 8'hFF, 16'hFFFF, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b0, 8'h00, 6'd0, 8'h00));
    add_row(ACT_SPARE_A, 8'hA5, 16'h5A5A, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b0, 8'h00, 6'd0, 8'h00));
    add_row(ACT_SPARE_B, 8'h5A, 16'hA5A5, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b0, 8'h00, 6'd0, 8'h00));
    add_row(sfs_pkg::ACT_PULSE, 8'h00, 16'h0000, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b0, 8'h00, 6'd0, 8'h00));
    add_row(sfs_pkg::ACT_TIMER, 8'h00, 16'h0000, 1'b1,
            mk_result(1'b1, 16'hFFFF, 1'b0, 8'h00, 6'd0, 8'h00));
    add_row(sfs_pkg::ACT_TIMER, 8'h00, 16'h0000, 1'b1,
            mk_result(1'b0, sfs_pkg::GAP_LOAD, 1'b1, 8'h00, 6'd0, 8'h00));
    add_row(sfs_pkg::ACT_RX, 8'hFF, 16'h0000, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b1, 8'h00, 6'd1, 8'h00));
    add_row(sfs_pkg::ACT_RX, 8'h00, 16'hFFFF, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b1, 8'h00, 6'd2, 8'h00));
    add_row(sfs_pkg::ACT_READ, 8'h00, 16'h0000, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b1, 8'hFF, 6'd1, 8'h00));
    add_row(sfs_pkg::ACT_READ, 8'h00, 16'h0000, 1'b1,
            mk_result(1'b0, 16'h0000, 1'b1, 8'h00, 6'd0, 8'h00));
    // read when empty returns the unwritten tail entry, which reads as zero
    add_row(sfs_pkg::ACT_READ, 8'h00, 16'h0000, 1'b0, '0);
    // pulse change applies at once
    add_row(sfs_pkg::ACT_PULSE, 8'h00, 16'hFFFF, 1'b0, '0);
    for (i = 0; i < 5; i++) add_row(sfs_pkg::ACT_TIMER, 8'h00, 16'h0000, 1'b0, '0);
    add_row(sfs_pkg::ACT_FRAMES, 8'h00, 16'h0000, 1'b0, '0);
    add_row(sfs_pkg::ACT_TIMER, 8'h00, 16'h0000, 1'b0, '0);
    add_row(sfs_pkg::ACT_RX, 8'h5A, 16'h0000, 1'b0, '0);
    add_row(sfs_pkg::ACT_FRAMES, 8'h00, 16'h0000, 1'b0, '0);
    foreach (directed_rows[k])
      send_item(directed_rows[k].act, directed_rows[k].rx, directed_rows[k].pw,
                directed_rows[k].typed, directed_rows[k].want);

    // random phases, each with its own offset; the last one without idling
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: phase_offset = 16'h0000;
        2: phase_offset = 16'hFFFF;
        default: phase_offset = 16'($urandom);
      endcase
      write_offset(phase_offset);
      if (ph == 3) idle_en = 1'b0;
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // open the receiver, then push 60 to 70 bytes, which may overrun the ring
          while (cur_slot < sfs_pkg::SLOT_GAP_BEG) begin
            send_random(sfs_pkg::ACT_TIMER);
            n++;
          end
          burst = $urandom_range(60, 70);
          repeat (burst) send_random(sfs_pkg::ACT_RX);
          n += burst;
        end else begin
          if (pick < 30) send_random(sfs_pkg::ACT_TIMER);
          else if (pick < 62) send_random(sfs_pkg::ACT_RX);
          else if (pick < 82) send_random(sfs_pkg::ACT_READ);
          else if (pick < 90) send_random(sfs_pkg::ACT_PULSE);
          else if (pick < 96) send_random(sfs_pkg::ACT_FRAMES);
          else send_random(3'($urandom_range(int'(ACT_SPARE_A), int'(ACT_SPARE_C))));
          n++;
        end
      end
    end

    settle();
    repeat (6) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("servo_frame_sequencer_rx_ring test passed");
    end else begin
      $display("servo_frame_sequencer_rx_ring test failed");
    end
    $finish;
  end

endmodule
